### rtl/core/nec_ir_pkg.sv
// Shared types and constants for the NEC IR frame decoder.
// No dependencies; used by nec_ir_pulse_if, nec_ir_cfg, the top level and the testbench.
package nec_ir_pkg;

	localparam int WIDTH_W    = 16;
	localparam int CFG_W      = 16;
	localparam int IDX_W      = 3;
	localparam int NUM_REGS   = 6;
	localparam int FRAME_BITS = 32;
	localparam int BITS_W     = 6;

	// tolerance is nominal/5; x/5 == (x * 52429) >> 18 for any 16-bit x
	localparam int TOL_DIV     = 5;
	localparam int RECIP_W     = 18;
	localparam int RECIP_SHIFT = 18;
	localparam logic [RECIP_W-1:0] TOL_RECIP = RECIP_W'((2 ** RECIP_SHIFT) / TOL_DIV + 1);

	typedef enum logic [IDX_W-1:0] {
		REG_LEADER_LOW   = 3'd0,
		REG_START_SPACE  = 3'd1,
		REG_REPEAT_SPACE = 3'd2,
		REG_BIT_MARK     = 3'd3,
		REG_ZERO_SPACE   = 3'd4,
		REG_ONE_SPACE    = 3'd5
	} reg_idx_t;

	localparam logic [CFG_W-1:0] RST_NOM [NUM_REGS] = '{
		16'd9000, 16'd4500, 16'd2250, 16'd560, 16'd560, 16'd1690
	};

	// acceptance window [lo, hi] for one nominal width
	typedef struct packed {
		logic [WIDTH_W-1:0] lo;
		logic [WIDTH_W:0]   hi;
	} win_t;

	typedef win_t [NUM_REGS-1:0] win_set_t;

	function automatic logic in_window(input logic [WIDTH_W-1:0] w, input win_t win);
		logic ge_lo;
		logic le_hi;
		ge_lo = (w >= win.lo);
		le_hi = ({1'b0, w} <= win.hi);
		return ge_lo && le_hi;
	endfunction

endpackage

### rtl/core/nec_ir_if.sv
// Valid/ready channel interfaces for pulse requests and decode results.
// Depends on nec_ir_pkg.
interface nec_ir_pulse_if;
	import nec_ir_pkg::*;

	logic               valid;
	logic               ready;
	logic               pulse_level;
	logic [WIDTH_W-1:0] width_us;

	modport source (output valid, output pulse_level, output width_us, input ready);
	modport sink   (input valid, input pulse_level, input width_us, output ready);
endinterface

interface nec_ir_result_if;
	logic       valid;
	logic       ready;
	logic       frame_ok;
	logic       repeat_code;
	logic [7:0] device_address;
	logic [7:0] command_code;

	modport source (output valid, output frame_ok, output repeat_code,
		output device_address, output command_code, input ready);
	modport sink   (input valid, input frame_ok, input repeat_code,
		input device_address, input command_code, output ready);
endinterface

### rtl/core/nec_ir_cfg.sv
// Timing registers: holds the acceptance window of each nominal width.
// Depends on nec_ir_pkg. Windows are computed once, at write time.
module nec_ir_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [nec_ir_pkg::IDX_W-1:0]   cfg_idx,
	input  logic [nec_ir_pkg::CFG_W-1:0]   cfg_data,
	output nec_ir_pkg::win_set_t           win
);
	import nec_ir_pkg::*;

	logic [CFG_W+RECIP_W-1:0] prod;
	logic [CFG_W-1:0]         tol;
	logic [WIDTH_W-1:0]       new_lo;
	logic [WIDTH_W:0]         new_hi;

	assign prod   = cfg_data * TOL_RECIP;
	assign tol    = prod[RECIP_SHIFT +: CFG_W];
	assign new_lo = cfg_data - tol;
	assign new_hi = {1'b0, cfg_data} + {1'b0, tol};

	for (genvar i = 0; i < NUM_REGS; i++) begin : g_reg
		localparam logic [WIDTH_W-1:0] RST_LO =
			WIDTH_W'(RST_NOM[i] - RST_NOM[i] / TOL_DIV);
		localparam logic [WIDTH_W:0]   RST_HI =
			(WIDTH_W+1)'({1'b0, RST_NOM[i]} + (RST_NOM[i] / TOL_DIV));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				win[i].lo <= RST_LO;
				win[i].hi <= RST_HI;
			end else if (cfg_we && cfg_idx == IDX_W'(i)) begin
				win[i].lo <= new_lo;
				win[i].hi <= new_hi;
			end
		end
	end

endmodule

### rtl/core/nec_ir_frame_decoder_top.sv
// NEC IR frame decoder top level: pulse request in, decode result out.
// Depends on nec_ir_pkg, nec_ir_if.sv and nec_ir_cfg.
//
// Each request is one measured line pulse (level, width in us). The decoder
// follows leader mark, leader space, then either a repeat code or 32 data
// bits sent LSB first, and returns address and command with frame_ok set when
// both complement bytes check. A pulse is accepted every cycle while results
// are taken; it is held in the input register, and its result, if any, is
// then registered in the result register. Only a result that is not taken
// stalls the input. Any mismatch returns a result with all fields zero;
// the pulse after a repeat leader and the stop bit produce no result. Timing
// registers may be written only while no pulse is in flight.
module nec_ir_frame_decoder_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [nec_ir_pkg::IDX_W-1:0] cfg_idx,
	input  logic [nec_ir_pkg::CFG_W-1:0] cfg_data,
	nec_ir_pulse_if.sink                 pulse,
	nec_ir_result_if.source              result
);
	import nec_ir_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE        = 3'd0,
		PH_LEAD_HIGH   = 3'd1,
		PH_REPEAT_TAIL = 3'd2,
		PH_BIT_MARK    = 3'd3,
		PH_BIT_SPACE   = 3'd4,
		PH_STOP        = 3'd5
	} phase_t;

	win_set_t win;

	nec_ir_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.win      (win)
	);

	// input register
	logic               vld_s1;
	logic               lvl_s1;
	logic [WIDTH_W-1:0] width_s1;
	logic               adv;

	assign adv         = !result.valid || result.ready;
	assign pulse.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (pulse.ready) begin
			vld_s1 <= pulse.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pulse.valid && pulse.ready) begin
			lvl_s1   <= pulse.pulse_level;
			width_s1 <= pulse.width_us;
		end
	end

	// decode
	phase_t               phase_q, phase_d;
	logic [BITS_W-1:0]    bits_q, bits_d, bits_inc;
	logic [FRAME_BITS-1:0] shift_q, shift_d;
	logic                 emit, fail, ok_d, rep_d;
	logic [7:0]           addr_d, cmd_d;
	logic near_lead, near_start, near_rep, near_mark, near_zero, near_one;

	assign near_lead  = in_window(width_s1, win[REG_LEADER_LOW]);
	assign near_start = in_window(width_s1, win[REG_START_SPACE]);
	assign near_rep   = in_window(width_s1, win[REG_REPEAT_SPACE]);
	assign near_mark  = in_window(width_s1, win[REG_BIT_MARK]);
	assign near_zero  = in_window(width_s1, win[REG_ZERO_SPACE]);
	assign near_one   = in_window(width_s1, win[REG_ONE_SPACE]);
	assign bits_inc   = bits_q + BITS_W'(1);

	always_comb begin
		phase_d = phase_q;
		bits_d  = bits_q;
		shift_d = shift_q;
		emit    = 1'b0;
		fail    = 1'b0;
		ok_d    = 1'b0;
		rep_d   = 1'b0;
		addr_d  = '0;
		cmd_d   = '0;
		unique case (phase_q)
			PH_LEAD_HIGH: begin
				if (!lvl_s1) begin
					fail = 1'b1;
				end else if (near_rep) begin
					phase_d = PH_REPEAT_TAIL;
					emit    = 1'b1;
					ok_d    = 1'b1;
					rep_d   = 1'b1;
				end else if (!near_start) begin
					fail = 1'b1;
				end else begin
					phase_d = PH_BIT_MARK;
					bits_d  = '0;
					shift_d = '0;
				end
			end
			PH_REPEAT_TAIL, PH_STOP: begin
				phase_d = PH_IDLE;
			end
			PH_BIT_MARK: begin
				if (lvl_s1 || !near_mark) begin
					fail = 1'b1;
				end else begin
					phase_d = PH_BIT_SPACE;
				end
			end
			PH_BIT_SPACE: begin
				if (!lvl_s1 || (!near_one && !near_zero)) begin
					fail = 1'b1;
				end else begin
					// LSB first: new bit enters at the top
					shift_d = {near_one, shift_q[FRAME_BITS-1:1]};
					if (bits_inc == BITS_W'(FRAME_BITS)) begin
						phase_d = PH_STOP;
						bits_d  = '0;
						emit    = 1'b1;
						addr_d  = shift_d[7:0];
						cmd_d   = shift_d[23:16];
						ok_d    = (shift_d[15:8] == ~shift_d[7:0]) &&
							(shift_d[31:24] == ~shift_d[23:16]);
					end else begin
						phase_d = PH_BIT_MARK;
						bits_d  = bits_inc;
					end
				end
			end
			default: begin
				// idle and unused codes; a high pulse here is dropped
				phase_d = PH_IDLE;
				if (!lvl_s1) begin
					if (near_lead) begin
						phase_d = PH_LEAD_HIGH;
					end else begin
						fail = 1'b1;
					end
				end
			end
		endcase
		if (fail) begin
			phase_d = PH_IDLE;
			bits_d  = '0;
			shift_d = '0;
			emit    = 1'b1;
			ok_d    = 1'b0;
			rep_d   = 1'b0;
			addr_d  = '0;
			cmd_d   = '0;
		end
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bits_q       <= '0;
			shift_q      <= '0;
			result.valid <= 1'b0;
		end else if (adv) begin
			result.valid <= vld_s1 && emit;
			if (vld_s1) begin
				phase_q <= phase_d;
				bits_q  <= bits_d;
				shift_q <= shift_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1 && emit) begin
			result.frame_ok       <= ok_d;
			result.repeat_code    <= rep_d;
			result.device_address <= addr_d;
			result.command_code   <= cmd_d;
		end
	end

	// checks
	a_bits_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_BIT_MARK && phase_q != PH_BIT_SPACE) |-> bits_q == '0)
		else $error("bit count not clear outside data phase");

	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q < BITS_W'(FRAME_BITS))
		else $error("bit count out of range");

	a_repeat_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.repeat_code) |->
		(result.frame_ok && result.device_address == 8'd0 && result.command_code == 8'd0))
		else $error("repeat result with bad fields");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(vld_s1))
		else $error("result without a request in the input register");

endmodule

### sim/tb.sv
// Self-checking testbench for nec_ir_frame_decoder_top: pulse requests in,
// decode results checked against an in-bench decoder model.
// Depends on nec_ir_pkg and the interfaces in nec_ir_if.sv.
`timescale 1ns / 1ps

module tb;
	import nec_ir_pkg::*;

	localparam int CLK_PERIOD    = 12;
	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 200000;

	localparam logic LOW  = 1'b0;
	localparam logic HIGH = 1'b1;

	// indexes past the last register; writes there must not land anywhere
	localparam logic [IDX_W-1:0] IDX_SPARE_LO = IDX_W'(NUM_REGS);
	localparam logic [IDX_W-1:0] IDX_SPARE_HI = IDX_W'(NUM_REGS + 1);

	typedef enum logic [2:0] {
		DEC_IDLE, DEC_LEAD_SPACE, DEC_REPEAT_TAIL, DEC_BIT_MARK, DEC_BIT_SPACE, DEC_STOP
	} dec_phase_t;

	typedef struct packed {
		logic       ok;
		logic       rep;
		logic [7:0] addr;
		logic [7:0] cmd;
	} nec_result_t;

	// what a directed row expects: nothing, an all-zero abort, a repeat, or ask the model
	typedef enum logic [1:0] {EXP_NONE, EXP_ABORT, EXP_REPEAT, EXP_MODEL} row_exp_t;

	typedef struct packed {
		logic          lvl;
		logic [15:0]   w;
		row_exp_t      kind;
	} pulse_row_t;

	localparam int DIR_COUNT = 27;
	localparam pulse_row_t DIR_ROWS [DIR_COUNT] = '{
		'{HIGH, 16'd65535, EXP_NONE},   // high while idle is ignored
		'{HIGH, 16'd0,     EXP_NONE},
		'{LOW,  16'd0,     EXP_ABORT},
		'{LOW,  16'd65535, EXP_ABORT},
		'{LOW,  16'd7199,  EXP_ABORT},  // one below leader window
		'{LOW,  16'd7200,  EXP_NONE},
		'{LOW,  16'd2250,  EXP_ABORT},  // wrong level for leader space
		'{LOW,  16'd10800, EXP_NONE},
		'{HIGH, 16'd1800,  EXP_REPEAT},
		'{LOW,  16'd0,     EXP_NONE},   // repeat tail swallowed
		'{LOW,  16'd9000,  EXP_NONE},
		'{HIGH, 16'd2700,  EXP_REPEAT},
		'{HIGH, 16'd65535, EXP_NONE},
		'{LOW,  16'd9000,  EXP_NONE},
		'{HIGH, 16'd3000,  EXP_ABORT},  // between repeat and start windows
		'{LOW,  16'd9000,  EXP_MODEL},
		'{HIGH, 16'd5400,  EXP_MODEL},
		'{HIGH, 16'd560,   EXP_ABORT},  // wrong level for bit mark
		'{LOW,  16'd9000,  EXP_MODEL},
		'{HIGH, 16'd3600,  EXP_MODEL},
		'{LOW,  16'd448,   EXP_MODEL},
		'{LOW,  16'd560,   EXP_ABORT},  // wrong level for bit space
		'{LOW,  16'd10801, EXP_ABORT},
		'{LOW,  16'd9000,  EXP_MODEL},
		'{HIGH, 16'd4500,  EXP_MODEL},
		'{LOW,  16'd672,   EXP_MODEL},
		'{HIGH, 16'd1000,  EXP_ABORT}   // space fits neither bit value
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [IDX_W-1:0]     cfg_idx;
	logic [CFG_W-1:0]     cfg_data;

	nec_ir_pulse_if  pulse_ch ();
	nec_ir_result_if result_ch ();

	nec_ir_frame_decoder_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.pulse    (pulse_ch),
		.result   (result_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// decoder model state
	logic [15:0]  nominal_us [NUM_REGS] = RST_NOM;
	dec_phase_t   dec_phase = DEC_IDLE;
	int           dec_bits = 0;
	logic [31:0]  dec_word = '0;

	nec_result_t  pending_decodes [$];
	nec_result_t  want;
	logic [15:0]  cfg_plan [NUM_REGS];
	int           decode_errors = 0;
	int           pulses_sent = 0;
	int unsigned  cycle_count = 0;
	bit           drive_gaps = 1'b1;

	function automatic logic in_tolerance(input logic [15:0] w, input logic [15:0] nom);
		int m;
		m = int'(nom) / TOL_DIV;
		return int'(w) >= int'(nom) - m && int'(w) <= int'(nom) + m;
	endfunction

	function automatic logic decode_pulse(input logic lvl, input logic [15:0] w,
			output nec_result_t res);
		logic        bad;
		logic        got;
		logic [31:0] word;
		bad = 1'b0;
		got = 1'b0;
		res = '0;
		case (dec_phase)
			DEC_LEAD_SPACE: begin
				if (!lvl) begin
					bad = 1'b1;
				end else if (in_tolerance(w, nominal_us[REG_REPEAT_SPACE])) begin
					dec_phase = DEC_REPEAT_TAIL;
					res.ok = 1'b1;
					res.rep = 1'b1;
					got = 1'b1;
				end else if (!in_tolerance(w, nominal_us[REG_START_SPACE])) begin
					bad = 1'b1;
				end else begin
					dec_phase = DEC_BIT_MARK;
					dec_bits = 0;
					dec_word = '0;
				end
			end
			DEC_REPEAT_TAIL, DEC_STOP: dec_phase = DEC_IDLE;
			DEC_BIT_MARK: begin
				if (lvl || !in_tolerance(w, nominal_us[REG_BIT_MARK]))
					bad = 1'b1;
				else
					dec_phase = DEC_BIT_SPACE;
			end
			DEC_BIT_SPACE: begin
				word = dec_word >> 1;
				if (!lvl)
					bad = 1'b1;
				else if (in_tolerance(w, nominal_us[REG_ONE_SPACE]))
					word[31] = 1'b1;
				else if (!in_tolerance(w, nominal_us[REG_ZERO_SPACE]))
					bad = 1'b1;
				if (!bad) begin
					dec_word = word;
					dec_bits++;
					if (dec_bits < FRAME_BITS) begin
						dec_phase = DEC_BIT_MARK;
					end else begin
						res.addr = word[7:0];
						res.cmd = word[23:16];
						res.ok = (word[15:8] == ~word[7:0]) && (word[31:24] == ~word[23:16]);
						got = 1'b1;
						dec_phase = DEC_STOP;
						dec_bits = 0;
					end
				end
			end
			default: begin
				if (!lvl) begin
					if (in_tolerance(w, nominal_us[REG_LEADER_LOW]))
						dec_phase = DEC_LEAD_SPACE;
					else
						bad = 1'b1;
				end
			end
		endcase
		if (bad) begin
			dec_phase = DEC_IDLE;
			dec_bits = 0;
			dec_word = '0;
			res = '0;
			got = 1'b1;
		end
		return got;
	endfunction

	// width inside the acceptance window, often right on its bounds
	function automatic logic [15:0] near_width(input logic [15:0] nom);
		int m;
		int lo;
		int hi;
		m = int'(nom) / TOL_DIV;
		lo = int'(nom) - m;
		hi = int'(nom) + m;
		if (hi > 65535)
			hi = 65535;
		case ($urandom_range(0, 3))
			0: return 16'(lo);
			1: return 16'(hi);
			default: return 16'($urandom_range(hi, lo));
		endcase
	endfunction

	function automatic logic [15:0] noise_width();
		logic [15:0] nom;
		int          m;
		int          rim;
		nom = nominal_us[$urandom_range(0, NUM_REGS - 1)];
		m = int'(nom) / TOL_DIV;
		case ($urandom_range(0, 2))
			0: return 16'($urandom);
			1: return near_width(nom);
			default: begin
				rim = $urandom_range(0, 1) ? int'(nom) + m + 1 : int'(nom) - m - 1;
				if (rim < 0)
					rim = 0;
				if (rim > 65535)
					rim = 65535;
				return 16'(rim);
			end
		endcase
	endfunction

	task automatic push_pulse(input logic lvl, input logic [15:0] w,
			input row_exp_t kind = EXP_MODEL);
		nec_result_t res;
		logic        got;
		if (drive_gaps && $urandom_range(0, 3) == 0) begin
			pulse_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		pulse_ch.valid <= 1'b1;
		pulse_ch.pulse_level <= lvl;
		pulse_ch.width_us <= w;
		@(posedge clk);
		while (!pulse_ch.ready) @(posedge clk);
		got = decode_pulse(lvl, w, res);
		case (kind)
			EXP_NONE: got = 1'b0;
			EXP_ABORT: begin
				got = 1'b1;
				res = '0;
			end
			EXP_REPEAT: begin
				got = 1'b1;
				res = '0;
				res.ok = 1'b1;
				res.rep = 1'b1;
			end
			default: ;
		endcase
		if (got)
			pending_decodes.push_back(res);
		pulses_sent++;
	endtask

	// pulse of a frame, or garbage at the position picked to break it
	task automatic frame_pulse(input logic lvl, input logic [15:0] w, inout int k,
			input int spoil);
		if (k == spoil)
			push_pulse(logic'($urandom_range(0, 1)), 16'($urandom));
		else
			push_pulse(lvl, w);
		k++;
	endtask

	task automatic send_frame();
		logic [31:0] word;
		int          spoil;
		int          k;
		word[7:0] = 8'($urandom);
		word[23:16] = 8'($urandom);
		word[15:8] = ~word[7:0];
		word[31:24] = ~word[23:16];
		if ($urandom_range(0, 3) == 0) begin
			word[15:8] = 8'($urandom);
			word[31:24] = 8'($urandom);
		end
		spoil = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2 * FRAME_BITS + 2) : -1;
		k = 0;
		frame_pulse(LOW, near_width(nominal_us[REG_LEADER_LOW]), k, spoil);
		frame_pulse(HIGH, near_width(nominal_us[REG_START_SPACE]), k, spoil);
		for (int b = 0; b < FRAME_BITS; b++) begin
			frame_pulse(LOW, near_width(nominal_us[REG_BIT_MARK]), k, spoil);
			frame_pulse(HIGH, near_width(word[b] ? nominal_us[REG_ONE_SPACE]
				: nominal_us[REG_ZERO_SPACE]), k, spoil);
		end
		frame_pulse(LOW, near_width(nominal_us[REG_BIT_MARK]), k, spoil);
	endtask

	task automatic run_phase(input int upto);
		int pick;
		while (pulses_sent < upto) begin
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				send_frame();
			end else if (pick < 8) begin
				push_pulse(LOW, near_width(nominal_us[REG_LEADER_LOW]));
				push_pulse(HIGH, near_width(nominal_us[REG_REPEAT_SPACE]));
				push_pulse(logic'($urandom_range(0, 1)), 16'($urandom));
			end else begin
				repeat ($urandom_range(1, 4))
					push_pulse(logic'($urandom_range(0, 1)), noise_width());
			end
		end
	endtask

	// stop requests, let every result out, then give the pipeline time to empty
	task automatic drain();
		pulse_ch.valid <= 1'b0;
		while (pending_decodes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_cfg();
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= reg_idx_t'(i);
			cfg_data <= cfg_plan[i];
			nominal_us[i] = cfg_plan[i];
			@(posedge clk);
		end
		cfg_idx <= IDX_SPARE_LO;
		cfg_data <= 16'($urandom);
		@(posedge clk);
		cfg_idx <= IDX_SPARE_HI;
		cfg_data <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_LEADER_LOW;
		cfg_data <= '0;
		pulse_ch.valid <= 1'b0;
		pulse_ch.pulse_level <= 1'b0;
		pulse_ch.width_us <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_ROWS[i])
			push_pulse(DIR_ROWS[i].lvl, DIR_ROWS[i].w, DIR_ROWS[i].kind);
		run_phase(600);

		drain();
		foreach (cfg_plan[i])
			cfg_plan[i] = 16'($urandom_range(50, 12000));
		apply_cfg();
		run_phase(950);

		// zero nominals: every window collapses to a single value
		drain();
		cfg_plan = '{default: 16'd0};
		apply_cfg();
		run_phase(1050);

		drain();
		cfg_plan = '{default: 16'hFFFF};
		apply_cfg();
		run_phase(1150);

		drain();
		cfg_plan[REG_LEADER_LOW] = 16'hFFFF;
		cfg_plan[REG_START_SPACE] = 16'd0;
		cfg_plan[REG_REPEAT_SPACE] = 16'd1;
		cfg_plan[REG_BIT_MARK] = 16'd0;
		cfg_plan[REG_ZERO_SPACE] = 16'hFFFF;
		cfg_plan[REG_ONE_SPACE] = 16'd0;
		apply_cfg();
		run_phase(1350);

		drain();
		drive_gaps = 1'b0;
		cfg_plan = RST_NOM;
		apply_cfg();
		run_phase(1620);

		drain();
		if (decode_errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (drive_gaps && $urandom_range(0, 2) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_decodes.size() == 0) begin
				$display("%0t: result with none expected: ok=%0b rep=%0b addr=%02h cmd=%02h",
					$time, result_ch.frame_ok, result_ch.repeat_code,
					result_ch.device_address, result_ch.command_code);
				decode_errors++;
			end else begin
				want = pending_decodes.pop_front();
				if (result_ch.frame_ok !== want.ok) begin
					$display("%0t: frame_ok expected %0b actual %0b",
						$time, want.ok, result_ch.frame_ok);
					decode_errors++;
				end
				if (result_ch.repeat_code !== want.rep) begin
					$display("%0t: repeat_code expected %0b actual %0b",
						$time, want.rep, result_ch.repeat_code);
					decode_errors++;
				end
				if (result_ch.device_address !== want.addr) begin
					$display("%0t: device_address expected %02h actual %02h",
						$time, want.addr, result_ch.device_address);
					decode_errors++;
				end
				if (result_ch.command_code !== want.cmd) begin
					$display("%0t: command_code expected %02h actual %02h",
						$time, want.cmd, result_ch.command_code);
					decode_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding",
				$time, pending_decodes.size());
			$display("Some tests failed");
			$finish;
		end
	end

endmodule
